>>> sv/ade_pkg.sv
// ----------------------------------------------------------------------------
// ade_pkg
// shared types and constants for the advertising data field extractor
// ----------------------------------------------------------------------------
`default_nettype none

package ade_pkg;

    // longest record the parser walks, in bytes
    localparam int RECORD_BYTES = 31;
    localparam logic [4:0] RECORD_MAX = 5'((RECORD_BYTES > 31) ? 31 : RECORD_BYTES);

    // register reset values
    localparam logic [7:0] MATCH_A_RESET = 8'h08;
    localparam logic [7:0] MATCH_B_RESET = 8'h09;
    localparam logic [4:0] MAX_PAYLOAD_RESET = 5'd29;

    // register indexes
    localparam logic [1:0] REG_MATCH_A = 2'd0;
    localparam logic [1:0] REG_MATCH_B = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_TYPE    = 3'd2,
        PH_SKIP    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] match_a;
        logic [7:0] match_b;
        logic [4:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [4:0] length;
    } item_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

>>> sv/ade_cfg.sv
// ----------------------------------------------------------------------------
// ade_cfg
// match type and payload limit registers
// ----------------------------------------------------------------------------
`default_nettype none

module ade_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [7:0]  wr_data,
    output ade_pkg::cfg_t    cfg
);
    import ade_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_MATCH_A:     cfg_next.match_a = wr_data;
                REG_MATCH_B:     cfg_next.match_b = wr_data;
                REG_MAX_PAYLOAD: cfg_next.max_payload = wr_data[4:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_a <= MATCH_A_RESET;
            cfg_reg.match_b <= MATCH_B_RESET;
            cfg_reg.max_payload <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/ade_walker.sv
// ----------------------------------------------------------------------------
// ade_walker
// length-type-value walker: state registers and one-byte step logic
// ----------------------------------------------------------------------------
`default_nettype none

module ade_walker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  ade_pkg::item_t   item,
    input  ade_pkg::cfg_t    cfg,
    output ade_pkg::res_t    res
);
    import ade_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [4:0] position_reg;
    logic [4:0] position_next;
    logic [4:0] total_reg;
    logic [4:0] total_next;
    logic [4:0] remain_reg;
    logic [4:0] remain_next;
    res_t       step_res;

    always_comb
    begin
        phase_t     ph;
        logic [4:0] pos;
        logic [4:0] tot;
        logic [4:0] rem;
        logic [4:0] rem_dec;
        logic [9:0] reach;
        logic       at_end;
        logic       is_match;
        logic       handled;

        ph = phase_reg;
        pos = position_reg;
        tot = total_reg;
        rem = remain_reg;
        handled = 1'b0;
        step_res = '0;
        step_res.kind = KIND_BYTE;

        // record start re-arms the walker, even mid-record
        if (item.start)
        begin
            tot = (item.length > RECORD_MAX) ? RECORD_MAX : item.length;
            pos = 5'd0;
            rem = 5'd0;
            if (tot == 5'd0)
            begin
                step_res.valid = 1'b1;
                step_res.kind = KIND_NONE;
                step_res.last = 1'b1;
                handled = 1'b1;
            end
            else
            begin
                ph = PH_LEN;
            end
        end

        rem_dec = rem - 5'd1;
        reach = 10'(pos) + 10'd1 + 10'(item.data);
        at_end = ((6'(pos) + 6'd1) >= 6'(tot));
        is_match = (item.data == cfg.match_a) || (item.data == cfg.match_b);

        if (!handled && ph != PH_IDLE && ph != PH_DONE)
        begin
            unique case (ph)
                PH_LEN:
                begin
                    if (item.data == 8'd0 || reach > 10'(tot))
                    begin
                        step_res.valid = 1'b1;
                        step_res.kind = KIND_NONE;
                        step_res.last = 1'b1;
                    end
                    else
                    begin
                        rem = item.data[4:0];
                        ph = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    rem = rem_dec;
                    if (is_match)
                    begin
                        if (rem_dec == 5'd0)
                        begin
                            step_res.valid = 1'b1;
                            step_res.kind = KIND_EMPTY;
                            step_res.last = 1'b1;
                        end
                        else if (rem_dec > cfg.max_payload)
                        begin
                            step_res.valid = 1'b1;
                            step_res.kind = KIND_NONE;
                            step_res.last = 1'b1;
                        end
                        else
                        begin
                            ph = PH_PAYLOAD;
                        end
                    end
                    else if (rem_dec == 5'd0)
                    begin
                        if (at_end)
                        begin
                            step_res.valid = 1'b1;
                            step_res.kind = KIND_NONE;
                            step_res.last = 1'b1;
                        end
                        else
                        begin
                            ph = PH_LEN;
                        end
                    end
                    else
                    begin
                        ph = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    rem = rem_dec;
                    if (rem_dec == 5'd0)
                    begin
                        if (at_end)
                        begin
                            step_res.valid = 1'b1;
                            step_res.kind = KIND_NONE;
                            step_res.last = 1'b1;
                        end
                        else
                        begin
                            ph = PH_LEN;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    rem = rem_dec;
                    step_res.valid = 1'b1;
                    step_res.kind = KIND_BYTE;
                    step_res.data = item.data;
                    step_res.last = (rem_dec == 5'd0);
                end
                default:
                begin
                    ph = phase_reg;
                end
            endcase
            pos = pos + 5'd1;
        end

        if (step_res.valid && step_res.last)
        begin
            ph = PH_DONE;
        end

        phase_next = ph;
        position_next = pos;
        total_next = tot;
        remain_next = rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            position_reg <= 5'd0;
            total_reg <= 5'd0;
            remain_reg <= 5'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            position_reg <= position_next;
            total_reg <= total_next;
            remain_reg <= remain_next;
        end
    end

    always_comb
    begin
        res = step_res;
        res.valid = step_res.valid && fire;
    end

endmodule

`default_nettype wire

>>> sv/adv_data_field_extractor.sv
// ----------------------------------------------------------------------------
// adv_data_field_extractor
// path: each byte passes the input register, then the walker step into the result register
// throughput: one byte per cycle while the result slot is not stalled
// reset: walker idle until a record start, registers at 0x08 / 0x09 / 29
// ----------------------------------------------------------------------------
`default_nettype none

module adv_data_field_extractor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte stream
    input  wire logic        data_valid,
    output logic             data_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        record_start,
    input  wire logic [4:0]  record_length,
    // results
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic             answer_last,
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import ade_pkg::*;

    cfg_t       cfg;
    res_t       res;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      in_item_reg;

    // result register
    logic       out_valid_reg;
    logic       out_valid_next;
    kind_t      out_kind_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic       out_free;
    logic       step_fire;
    logic       data_take;

    // register writes are always taken; the port must only run while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    ade_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // result slot can take a new value when empty or being drained
    assign out_free = !out_valid_reg || !result_stall;
    // walker steps once the result slot is free
    assign step_fire = in_valid_reg && out_free;
    // hold the byte stream while the input register cannot move on
    assign data_stall = in_valid_reg && !out_free;
    assign data_take = data_valid && !data_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (data_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload of the input transaction, no reset needed
    always_ff @(posedge clk)
    begin
        if (data_take)
        begin
            in_item_reg.data <= data_byte;
            in_item_reg.start <= record_start;
            in_item_reg.length <= record_length;
        end
    end

    ade_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (step_fire),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // a step without a result still empties a drained slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_fire)
        begin
            out_valid_next = res.valid;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_kind_reg <= res.kind;
            out_data_reg <= res.data;
            out_last_reg <= res.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind = out_kind_reg;
    assign payload_byte = out_data_reg;
    assign answer_last = out_last_reg;

    // empty match and not found always close the record
    a_final_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != KIND_BYTE |-> answer_last)
        else $error("non-payload result without answer_last");

    // only payload results carry a byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != KIND_BYTE |-> payload_byte == 8'd0)
        else $error("payload byte set on a non-payload result");

    // the byte stream is held only behind a waiting input register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> in_valid_reg && result_valid && result_stall)
        else $error("byte stream stalled without a blocked result");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the advertising data field extractor
// drives records byte by byte, predicts each answer with an independent
// walker model or a typed-in check, and compares each result transaction field by field
// ----------------------------------------------------------------------------

module tb_top;

    import ade_pkg::*;

    // clocking and run control
    localparam int CLK_HALF       = 4;
    localparam int SETTLE_CYCLES  = 4;     // drain time for the input and result registers, plus margin
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
    localparam int BYTES_PER_SET  = 115;   // byte transactions per register setting
    localparam int NUM_SETTINGS   = 6;

    // register index the block does not decode
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // one answer as the block should emit it
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } answer_t;

    // directed script: a byte transaction or a register write
    typedef enum logic {
        ROW_BYTE,
        ROW_REG
    } row_op_t;

    // how a row's answer is known: from the walker model or typed in
    typedef enum logic [2:0] {
        CHK_MODEL,
        CHK_QUIET,
        CHK_NOT_FOUND,
        CHK_EMPTY,
        CHK_BYTE,
        CHK_BYTE_LAST
    } chk_t;

    typedef struct packed {
        row_op_t    op;
        logic [7:0] data;     // byte, or register value
        logic       start;
        logic [4:0] length;
        logic [1:0] index;    // register rows only
        chk_t       chk;
    } row_t;

    localparam int NUM_ROWS = 30;

    // directed script, starting from the reset register values (a 0x08, b 0x09, max 29)
    localparam row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        // byte before any record start is ignored
        '{ROW_BYTE, 8'h12, 1'b0, 5'd0,  REG_MATCH_A, CHK_QUIET},
        // empty record answers on the start byte
        '{ROW_BYTE, 8'hAA, 1'b1, 5'd0,  REG_MATCH_A, CHK_NOT_FOUND},
        // zero length byte
        '{ROW_BYTE, 8'h00, 1'b1, 5'd3,  REG_MATCH_A, CHK_NOT_FOUND},
        // field running past the record end
        '{ROW_BYTE, 8'h03, 1'b1, 5'd3,  REG_MATCH_A, CHK_NOT_FOUND},
        // skip one field, then an empty match on type a
        '{ROW_BYTE, 8'h02, 1'b1, 5'd5,  REG_MATCH_A, CHK_QUIET},
        '{ROW_BYTE, 8'h01, 1'b0, 5'd31, REG_MATCH_A, CHK_MODEL},
        '{ROW_BYTE, 8'hFF, 1'b0, 5'd0,  REG_MATCH_A, CHK_MODEL},
        '{ROW_BYTE, 8'h01, 1'b0, 5'd17, REG_MATCH_A, CHK_MODEL},
        '{ROW_BYTE, 8'h08, 1'b0, 5'd0,  REG_MATCH_A, CHK_EMPTY},
        // three payload bytes from a type b field
        '{ROW_BYTE, 8'h04, 1'b1, 5'd6,  REG_MATCH_A, CHK_QUIET},
        '{ROW_BYTE, 8'h09, 1'b0, 5'd0,  REG_MATCH_A, CHK_QUIET},
        '{ROW_BYTE, 8'h00, 1'b0, 5'd31, REG_MATCH_A, CHK_BYTE},
        '{ROW_BYTE, 8'hFF, 1'b0, 5'd0,  REG_MATCH_A, CHK_BYTE},
        '{ROW_BYTE, 8'h5A, 1'b0, 5'd9,  REG_MATCH_A, CHK_BYTE_LAST},
        // byte after the answer is ignored
        '{ROW_BYTE, 8'h77, 1'b0, 5'd0,  REG_MATCH_A, CHK_QUIET},
        // end of record reached without a match
        '{ROW_BYTE, 8'h01, 1'b1, 5'd4,  REG_MATCH_A, CHK_MODEL},
        '{ROW_BYTE, 8'h07, 1'b0, 5'd0,  REG_MATCH_A, CHK_MODEL},
        '{ROW_BYTE, 8'h01, 1'b0, 5'd0,  REG_MATCH_A, CHK_MODEL},
        '{ROW_BYTE, 8'h10, 1'b0, 5'd0,  REG_MATCH_A, CHK_NOT_FOUND},
        // longest record, then abandoned by a new start mid-record
        '{ROW_BYTE, 8'h1E, 1'b1, 5'd31, REG_MATCH_A, CHK_QUIET},
        '{ROW_BYTE, 8'h01, 1'b1, 5'd2,  REG_MATCH_A, CHK_QUIET},
        '{ROW_BYTE, 8'h09, 1'b0, 5'd0,  REG_MATCH_A, CHK_EMPTY},
        // payload too long once the capacity is zero
        '{ROW_REG,  8'h00, 1'b0, 5'd0,  REG_MAX_PAYLOAD, CHK_MODEL},
        '{ROW_BYTE, 8'h02, 1'b1, 5'd3,  REG_MATCH_A, CHK_QUIET},
        '{ROW_BYTE, 8'h08, 1'b0, 5'd0,  REG_MATCH_A, CHK_NOT_FOUND},
        // type extremes, and a write to an undecoded index
        '{ROW_REG,  8'hFF, 1'b0, 5'd0,  REG_MATCH_A, CHK_MODEL},
        '{ROW_REG,  8'h00, 1'b0, 5'd0,  REG_MATCH_B, CHK_MODEL},
        '{ROW_REG,  8'h5A, 1'b0, 5'd0,  REG_UNUSED, CHK_MODEL},
        '{ROW_BYTE, 8'h01, 1'b1, 5'd2,  REG_MATCH_A, CHK_MODEL},
        '{ROW_BYTE, 8'h00, 1'b0, 5'd0,  REG_MATCH_A, CHK_EMPTY}
    };

    // dut signals, inputs known from time zero
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       data_valid    = 1'b0;
    logic       data_stall;
    logic [7:0] data_byte     = 8'h00;
    logic       record_start  = 1'b0;
    logic [4:0] record_length = 5'd0;
    logic       result_valid;
    logic       result_stall  = 1'b0;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       answer_last;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index     = 2'd0;
    logic [7:0] cfg_data      = 8'h00;

    // walker model state and its copy of the registers
    phase_t     walk_phase      = PH_IDLE;
    logic [4:0] walk_pos        = 5'd0;
    logic [4:0] walk_total      = 5'd0;
    logic [4:0] field_left      = 5'd0;
    logic [7:0] reg_match_a     = MATCH_A_RESET;
    logic [7:0] reg_match_b     = MATCH_B_RESET;
    logic [4:0] reg_max_payload = MAX_PAYLOAD_RESET;

    // answers predicted but not yet seen, oldest first
    answer_t pending_answers [$];

    // idling profile, in percent per cycle
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // run statistics
    int unsigned fail_count      = 0;
    int unsigned sent_bytes      = 0;
    int unsigned walked_bytes    = 0;
    int unsigned records_sent    = 0;
    int unsigned answers_checked = 0;
    int unsigned reg_writes      = 0;
    int unsigned quiet_cycles    = 0;

    adv_data_field_extractor uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_valid    (data_valid),
        .data_stall    (data_stall),
        .data_byte     (data_byte),
        .record_start  (record_start),
        .record_length (record_length),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .answer_last   (answer_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // walker model: one accepted byte transaction in, at most one answer out
    task automatic predict_byte(input logic [7:0] b, input logic s, input logic [4:0] l,
                                output bit has, output answer_t ans, output bit took);
        bit not_found;
        bit field_done;
        has        = 1'b0;
        took       = 1'b0;
        not_found  = 1'b0;
        field_done = 1'b0;
        ans        = '{KIND_BYTE, 8'h00, 1'b0};
        if (s)
        begin
            walk_total = (l > RECORD_MAX) ? RECORD_MAX : l;
            walk_pos   = 5'd0;
            field_left = 5'd0;
            took       = 1'b1;
            // empty record: answered here, the byte itself is not parsed
            if (walk_total == 5'd0)
                not_found = 1'b1;
            else
                walk_phase = PH_LEN;
        end
        if (!not_found && walk_phase != PH_IDLE && walk_phase != PH_DONE)
        begin
            took = 1'b1;
            case (walk_phase)
                PH_LEN:
                begin
                    // the whole field, length byte included, has to fit
                    if (b == 8'h00 || int'(walk_pos) + 1 + int'(b) > int'(walk_total))
                        not_found = 1'b1;
                    else
                    begin
                        field_left = b[4:0];
                        walk_phase = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    field_left = field_left - 5'd1;
                    if (b == reg_match_a || b == reg_match_b)
                    begin
                        if (field_left == 5'd0)
                        begin
                            has = 1'b1;
                            ans = '{KIND_EMPTY, 8'h00, 1'b1};
                        end
                        else if (field_left > reg_max_payload)
                            not_found = 1'b1;
                        else
                            walk_phase = PH_PAYLOAD;
                    end
                    else if (field_left == 5'd0)
                        field_done = 1'b1;
                    else
                        walk_phase = PH_SKIP;
                end
                PH_SKIP:
                begin
                    field_left = field_left - 5'd1;
                    field_done = (field_left == 5'd0);
                end
                PH_PAYLOAD:
                begin
                    field_left = field_left - 5'd1;
                    has = 1'b1;
                    ans = '{KIND_BYTE, b, field_left == 5'd0};
                end
                default:
                begin
                end
            endcase
            // a field just closed: either the record is used up or a new field follows
            if (field_done)
            begin
                if (int'(walk_pos) + 1 >= int'(walk_total))
                    not_found = 1'b1;
                else
                    walk_phase = PH_LEN;
            end
            walk_pos = walk_pos + 5'd1;
        end
        if (not_found)
        begin
            has = 1'b1;
            ans = '{KIND_NONE, 8'h00, 1'b1};
        end
        if (has && ans.last)
            walk_phase = PH_DONE;
    endtask

    // one byte transaction with a random gap ahead of it, then its answer queued
    task automatic feed(input logic [7:0] b, input logic s, input logic [4:0] l,
                        input chk_t chk);
        bit      has;
        bit      took;
        answer_t ans;
        cfg_valid <= 1'b0;
        if ($urandom_range(99) < send_idle_pct)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        data_valid    <= 1'b1;
        data_byte     <= b;
        record_start  <= s;
        record_length <= l;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        predict_byte(b, s, l, has, ans, took);
        // rows with a typed answer override the model's
        case (chk)
            CHK_QUIET:
            begin
                has = 1'b0;
            end
            CHK_NOT_FOUND:
            begin
                has = 1'b1;
                ans = '{KIND_NONE, 8'h00, 1'b1};
            end
            CHK_EMPTY:
            begin
                has = 1'b1;
                ans = '{KIND_EMPTY, 8'h00, 1'b1};
            end
            CHK_BYTE:
            begin
                has = 1'b1;
                ans = '{KIND_BYTE, b, 1'b0};
            end
            CHK_BYTE_LAST:
            begin
                has = 1'b1;
                ans = '{KIND_BYTE, b, 1'b1};
            end
            default:
            begin
            end
        endcase
        if (has)
            pending_answers.push_back(ans);
        sent_bytes++;
        if (took)
            walked_bytes++;
        if (s)
            records_sent++;
    endtask

    // stop sending until every predicted answer is out and the pipeline has drained
    task automatic wait_idle();
        data_valid <= 1'b0;
        cfg_valid  <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write transaction; the block is idle whenever this is called
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MATCH_A:     reg_match_a = value;
            REG_MATCH_B:     reg_match_b = value;
            REG_MAX_PAYLOAD: reg_max_payload = value[4:0];
            default:
            begin
            end
        endcase
        reg_writes++;
    endtask

    // one record of well-formed fields with random content, now and then broken
    task automatic play_record();
        logic [7:0] rec_bytes [$];
        int         rec_len;
        int         room;
        int         flen;
        int         cut;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 5)
            rec_len = 0;
        else if (roll < 75)
            rec_len = $urandom_range(12, 1);
        else
            rec_len = $urandom_range(31, 13);
        while (rec_bytes.size() < rec_len)
        begin
            room = rec_len - rec_bytes.size();
            if (room == 1)
                rec_bytes.push_back(8'($urandom_range(255)));
            else
            begin
                // mostly short fields, sometimes one of any length up to the rest of the record
                if ($urandom_range(3) == 0)
                    flen = $urandom_range(room - 1, 1);
                else
                    flen = $urandom_range((room - 1 < 6) ? room - 1 : 6, 1);
                roll = $urandom_range(99);
                if (roll < 4)
                    rec_bytes.push_back(8'h00);
                else if (roll < 9)
                    rec_bytes.push_back(8'($urandom_range(255)));
                else
                    rec_bytes.push_back(8'(flen));
                roll = $urandom_range(99);
                if (roll < 30)
                    rec_bytes.push_back(reg_match_a);
                else if (roll < 55)
                    rec_bytes.push_back(reg_match_b);
                else
                    rec_bytes.push_back(8'($urandom_range(255)));
                repeat (flen - 1) rec_bytes.push_back(8'($urandom_range(255)));
            end
        end
        if (rec_len == 0)
            feed(8'($urandom_range(255)), 1'b1, 5'd0, CHK_MODEL);
        else
        begin
            // a cut record is abandoned by the next record start
            if (rec_len > 1 && $urandom_range(99) < 12)
                cut = $urandom_range(rec_len - 1, 1);
            else
                cut = rec_len;
            for (int i = 0; i < cut; i++)
                feed(rec_bytes[i], i == 0,
                     (i == 0) ? 5'(rec_len) : 5'($urandom_range(31)), CHK_MODEL);
        end
        // trailing noise, ignored once the record has answered
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(3, 1))
                feed(8'($urandom_range(255)), 1'b0, 5'($urandom_range(31)), CHK_MODEL);
    endtask

    // result checker: each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result: kind %0d, payload_byte %02h, answer_last %0d",
                       kind, payload_byte, answer_last);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, kind);
                    fail_count++;
                end
                if (payload_byte !== want.data)
                begin
                    $error("payload_byte: expected %02h, actual %02h", want.data, payload_byte);
                    fail_count++;
                end
                if (answer_last !== want.last)
                begin
                    $error("answer_last: expected %0d, actual %0d", want.last, answer_last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction on any channel
    always @(posedge clk)
    begin
        if ((data_valid && !data_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d answers still pending", pending_answers.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        row_t row;
        int   setting;
        int   set_start;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script with the sender lightly idle and the receiver mostly stalled
        send_idle_pct  = 22;
        recv_stall_pct = 82;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.op == ROW_REG)
            begin
                wait_idle();
                write_reg(row.index, row.data);
            end
            else
                feed(row.data, row.start, row.length, row.chk);
        end

        // random records under several register settings and idling profiles
        for (setting = 0; setting < NUM_SETTINGS; setting++)
        begin
            case (setting / 2)
                0:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 82;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 22;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            wait_idle();
            case (setting)
                0:
                begin
                    write_reg(REG_MATCH_A, MATCH_A_RESET);
                    write_reg(REG_MATCH_B, MATCH_B_RESET);
                    write_reg(REG_MAX_PAYLOAD, 8'(MAX_PAYLOAD_RESET));
                end
                1:
                begin
                    write_reg(REG_MATCH_A, 8'h00);
                    write_reg(REG_MATCH_B, 8'hFF);
                    write_reg(REG_MAX_PAYLOAD, 8'd31);
                end
                2:
                begin
                    write_reg(REG_MATCH_A, 8'($urandom_range(255)));
                    write_reg(REG_MATCH_B, 8'($urandom_range(255)));
                    write_reg(REG_MAX_PAYLOAD, 8'd0);
                end
                4:
                begin
                    write_reg(REG_MATCH_A, 8'hFF);
                    write_reg(REG_MATCH_B, 8'h00);
                    write_reg(REG_MAX_PAYLOAD, 8'($urandom_range(31, 1)));
                end
                default:
                begin
                    write_reg(REG_MATCH_A, 8'($urandom_range(255)));
                    write_reg(REG_MATCH_B, 8'($urandom_range(255)));
                    write_reg(REG_MAX_PAYLOAD, 8'($urandom_range(31)));
                end
            endcase
            set_start = sent_bytes;
            while (sent_bytes - set_start < BYTES_PER_SET)
            begin
                // occasionally hold the sender until the answers have drained
                if ($urandom_range(49) == 0)
                    wait_idle();
                play_record();
            end
        end

        wait_idle();
        $display("covered %0d byte transactions (%0d walked) in %0d records, %0d answers checked",
                 sent_bytes, walked_bytes, records_sent, answers_checked);
        $display("%0d register writes across %0d settings and three idling profiles",
                 reg_writes, NUM_SETTINGS);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
sv/ade_pkg.sv
sv/ade_cfg.sv
sv/ade_walker.sv
sv/adv_data_field_extractor.sv
tb/tb_top.sv
